@@ hw/rtl/rwe_pkg.sv @@
// Shared types and constants for the rotary wheel event decoder.
package rwe_pkg;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned DEBOUNCE_W = 4;
    localparam int unsigned LONG_W     = 12;
    localparam int unsigned SETTLE_W   = 10;
    // tick counter only ever counts up to the largest hold time
    localparam int unsigned TICK_W     = LONG_W;

    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 16'd0;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 4'd3;
    localparam logic [LONG_W-1:0]     LONG_RST     = 12'd500;
    localparam logic [SETTLE_W-1:0]   SETTLE_RST   = 10'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE   = 2'd3;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_LEFT        = 4'd1,
        EV_RIGHT       = 4'd2,
        EV_PRESS       = 4'd3,
        EV_LONG        = 4'd4,
        EV_PRESS_BEGIN = 4'd5,
        EV_PRESS_END   = 4'd6,
        EV_PRESS_LEFT  = 4'd7,
        EV_PRESS_RIGHT = 4'd8
    } wheel_event_t;

endpackage

@@ hw/rtl/rotary_wheel_event_decoder.sv @@
// Rotary wheel event decoder: per-tick wheel and button sampling into wheel events.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata[0] pin_right, [1] pin_left, [2] pin_button
//  m_      | out | m_tvalid / m_tready  | m_tdata[3:0] wheel_event
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
// Each item is one tick: it is decoded while it sits in the input register, and its
// event (if any) is registered into the output register when the decoder advances.
// One item per cycle sustained while the output is not held.
// Reset (aresetn low, synchronous) clears both stages and loads register defaults.
// A held output stalls decode; the input register still takes one item meanwhile.
module rotary_wheel_event_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rwe_pkg::IN_DATA_W-1:0]    s_tdata,   // pin_right, pin_left, pin_button
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rwe_pkg::OUT_DATA_W-1:0]   m_tdata,   // wheel_event
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rwe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rwe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rwe_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_DETENT,
        PH_TURN,
        PH_DEB_DETENT,
        PH_DEB_TURN,
        PH_HOLD,
        PH_SETTLE_DELAY,
        PH_SETTLE
    } phase_t;

    // configuration
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [LONG_W-1:0]     long_press_reg;
    logic [SETTLE_W-1:0]   settle_reg;

    // input stage
    logic in_valid_reg, pin_r_reg, pin_l_reg, pin_b_reg;

    // decoder state
    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [TIMEOUT_W-1:0] timeout_left_reg, timeout_left_next;
    logic start_right_reg, start_right_next;
    logic start_left_reg, start_left_next;
    logic press_en_reg, press_en_next;
    logic press_turn_reg, press_turn_next;
    logic held_right_reg, held_right_next;

    // output stage
    logic         out_valid_reg;
    wheel_event_t event_reg;

    logic         advance, process;
    logic         res_valid;
    wheel_event_t res_event;

    // working values after the wait-start step
    phase_t               ph;
    logic [TICK_W-1:0]    tc;
    logic [TIMEOUT_W-1:0] tl;
    logic                 pe;
    logic [TICK_W:0]      tc_inc;
    logic [TIMEOUT_W-1:0] deb_ext;
    logic                 tmo_on, tmo_spent;
    logic                 turn_hit, turn_right;
    logic                 r, l, b;

    assign advance   = !out_valid_reg || m_tready;
    assign process   = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OUT_DATA_W-4){1'b0}}, event_reg};

    assign r = pin_r_reg;
    assign l = pin_l_reg;
    assign b = pin_b_reg;

    assign deb_ext = {{(TIMEOUT_W-DEBOUNCE_W){1'b0}}, debounce_reg};
    assign tmo_on  = (timeout_reg != '0);

    always_comb begin
        press_en_next    = press_en_reg;
        press_turn_next  = press_turn_reg;
        start_right_next = start_right_reg;
        start_left_next  = start_left_reg;
        held_right_next  = held_right_reg;
        res_valid        = 1'b0;
        res_event        = EV_NONE;

        ph = phase_reg;
        tc = tick_reg;
        tl = timeout_left_reg;
        pe = press_en_reg;

        // a new wait opens and runs its first detent check in the same tick
        if (phase_reg == PH_START) begin
            pe            = b;
            press_en_next = b;
            if (b && press_turn_reg) begin
                press_turn_next = 1'b0;
                res_valid       = 1'b1;
                res_event       = EV_PRESS_END;
            end else begin
                tl = timeout_reg;
                tc = '0;
                ph = PH_DETENT;
            end
        end

        phase_next        = ph;
        tick_next         = tc;
        timeout_left_next = tl;
        tc_inc            = {1'b0, tc} + (TICK_W+1)'(1);
        tmo_spent         = tmo_on && (tl <= deb_ext);
        turn_hit          = start_right_reg ? (!r || !l) : (r || l);
        turn_right        = start_right_reg ? !r : r;

        if (!res_valid) begin
            unique case (ph)
                PH_START: begin
                end
                PH_DETENT: begin
                    if (r == l) begin
                        if (tmo_spent) begin
                            res_valid = 1'b1;
                        end else begin
                            start_right_next  = r;
                            timeout_left_next = timeout_reg;
                            tick_next         = '0;
                            phase_next        = PH_TURN;
                        end
                    end else begin
                        tick_next = tc_inc[TICK_W-1:0];
                        if (tc_inc >= {{(TICK_W+1-DEBOUNCE_W){1'b0}}, debounce_reg}) begin
                            tick_next = '0;
                            if (tmo_spent) begin
                                res_valid = 1'b1;
                            end else begin
                                if (tmo_on) timeout_left_next = tl - deb_ext;
                                if (pe && !b) phase_next = PH_DEB_DETENT;
                            end
                        end
                    end
                end
                PH_TURN: begin
                    if (tmo_on && tl == '0) begin
                        res_valid = 1'b1;
                    end else if (turn_hit) begin
                        held_right_next = turn_right;
                        tick_next       = '0;
                        phase_next      = PH_SETTLE_DELAY;
                    end else if (pe && !b) begin
                        tick_next  = '0;
                        phase_next = PH_DEB_TURN;
                    end else if (b && press_turn_reg) begin
                        press_turn_next = 1'b0;
                        res_valid       = 1'b1;
                        res_event       = EV_PRESS_END;
                    end else if (tl != '0) begin
                        timeout_left_next = tl - TIMEOUT_W'(1);
                    end
                end
                PH_DEB_DETENT, PH_DEB_TURN: begin
                    if (b) begin
                        // released during debounce: back to the wait we came from
                        tick_next  = '0;
                        phase_next = (ph == PH_DEB_DETENT) ? PH_DETENT : PH_TURN;
                    end else begin
                        tick_next = tc_inc[TICK_W-1:0];
                        if (tc_inc >= {{(TICK_W+1-DEBOUNCE_W){1'b0}}, debounce_reg}) begin
                            start_right_next = r;
                            start_left_next  = l;
                            tick_next        = '0;
                            phase_next       = PH_HOLD;
                        end
                    end
                end
                PH_HOLD: begin
                    if (b) begin
                        res_valid = 1'b1;
                        res_event = EV_PRESS;
                    end else if (tc >= long_press_reg) begin
                        res_valid = 1'b1;
                        res_event = EV_LONG;
                    end else if (r != start_right_reg || l != start_left_reg) begin
                        press_turn_next = 1'b1;
                        res_valid       = 1'b1;
                        res_event       = EV_PRESS_BEGIN;
                    end else begin
                        tick_next = tc_inc[TICK_W-1:0];
                    end
                end
                PH_SETTLE_DELAY: begin
                    tick_next = tc_inc[TICK_W-1:0];
                    if (tc_inc >= {{(TICK_W+1-DEBOUNCE_W){1'b0}}, debounce_reg}) begin
                        tick_next  = '0;
                        phase_next = PH_SETTLE;
                    end
                end
                PH_SETTLE: begin
                    if (r == l) begin
                        res_valid = 1'b1;
                        // back at the starting level counts as no turn
                        if (r != start_right_reg) begin
                            if (pe) res_event = held_right_reg ? EV_RIGHT : EV_LEFT;
                            else    res_event = held_right_reg ? EV_PRESS_RIGHT : EV_PRESS_LEFT;
                        end
                    end else begin
                        tick_next = tc_inc[TICK_W-1:0];
                        if (tc_inc >= {{(TICK_W+1-SETTLE_W){1'b0}}, settle_reg}) begin
                            res_valid = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (res_valid) begin
            phase_next = PH_START;
            tick_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg      <= TIMEOUT_RST;
            debounce_reg     <= DEBOUNCE_RST;
            long_press_reg   <= LONG_RST;
            settle_reg       <= SETTLE_RST;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= PH_START;
            tick_reg         <= '0;
            timeout_left_reg <= '0;
            start_right_reg  <= 1'b0;
            start_left_reg   <= 1'b0;
            press_en_reg     <= 1'b0;
            press_turn_reg   <= 1'b0;
            held_right_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_TIMEOUT:  timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                    CFG_DEBOUNCE: debounce_reg   <= cfg_data[DEBOUNCE_W-1:0];
                    CFG_LONG:     long_press_reg <= cfg_data[LONG_W-1:0];
                    CFG_SETTLE:   settle_reg     <= cfg_data[SETTLE_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (s_tready) begin
                in_valid_reg <= s_tvalid;
                if (s_tvalid) begin
                    pin_r_reg <= s_tdata[0];
                    pin_l_reg <= s_tdata[1];
                    pin_b_reg <= s_tdata[2];
                end
            end

            if (advance) begin
                out_valid_reg <= process && res_valid;
                if (process && res_valid) event_reg <= res_event;
            end

            if (process) begin
                phase_reg        <= phase_next;
                tick_reg         <= tick_next;
                timeout_left_reg <= timeout_left_next;
                start_right_reg  <= start_right_next;
                start_left_reg   <= start_left_next;
                press_en_reg     <= press_en_next;
                press_turn_reg   <= press_turn_next;
                held_right_reg   <= held_right_next;
            end
        end
    end

endmodule

@@ hw/rtl/rwe_checker.sv @@
// Port-level assertions for the rotary wheel event decoder, bound to the top level.
module rwe_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rwe_pkg::OUT_DATA_W-1:0] m_tdata
);
    import rwe_pkg::*;

    // a stalled item stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // only a stalled output may back-pressure the input
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // event codes stay in range, upper bits zero
    a_event_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:4] == '0) && (m_tdata[3:0] <= EV_PRESS_RIGHT))
        else $error("wheel event code out of range");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind rotary_wheel_event_decoder rwe_checker u_rwe_checker (.*);

@@ tb/sv/rotary_wheel_event_decoder_tb.sv @@
// Self-checking testbench for the rotary wheel event decoder: directed and random tick streams.
module rotary_wheel_event_decoder_tb;
    import rwe_pkg::*;

    localparam int unsigned HALF_PERIOD  = 2;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum logic [2:0] {
        WAIT_START,
        WAIT_DETENT,
        WAIT_TURN,
        DEB_DETENT,
        DEB_TURN,
        BTN_HOLD,
        SETTLE_DLY,
        SETTLE_WIN
    } wait_phase_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;   // [0] pin_right, [1] pin_left, [2] pin_button
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;          // [3:0] wheel_event
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // register copies
    logic [TIMEOUT_W-1:0]   reg_timeout  = TIMEOUT_RST;
    logic [DEBOUNCE_W-1:0]  reg_debounce = DEBOUNCE_RST;
    logic [LONG_W-1:0]      reg_long     = LONG_RST;
    logic [SETTLE_W-1:0]    reg_settle   = SETTLE_RST;

    // decoder state copy
    wait_phase_t            wp_phase      = WAIT_START;
    logic [15:0]            wp_ticks      = '0;
    logic [15:0]            wp_tmo_left   = '0;
    logic                   wp_start_r    = 1'b0;
    logic                   wp_start_l    = 1'b0;
    logic                   wp_press_en   = 1'b0;
    logic                   wp_press_turn = 1'b0;
    wheel_event_t           wp_held       = EV_NONE;

    wheel_event_t           pending_events[$];
    int unsigned            ticks_sent    = 0;
    int unsigned            error_count   = 0;
    int unsigned            send_idle_pct = 17;
    int unsigned            recv_idle_pct = 45;
    int unsigned            quiet_cycles  = 0;

    rotary_wheel_event_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // one tick of the wheel decoder; returns 1 when the tick yields an output item (possibly EV_NONE)
    function automatic bit decode_tick(input bit r, input bit l, input bit b,
                                       output wheel_event_t ev);
        bit           done;
        wheel_event_t turn;
        done = 1'b0;
        ev   = EV_NONE;
        if (wp_phase == WAIT_START) begin
            wp_press_en = b;
            if (b && wp_press_turn) begin
                wp_press_turn = 1'b0;
                ev            = EV_PRESS_END;
                done          = 1'b1;
            end else begin
                wp_tmo_left = reg_timeout;
                wp_ticks    = '0;
                wp_phase    = WAIT_DETENT;
            end
        end
        if (!done) begin
            case (wp_phase)
                WAIT_DETENT: begin
                    if (r == l) begin
                        if (reg_timeout != 0 && wp_tmo_left <= reg_debounce) begin
                            done = 1'b1;
                        end else begin
                            wp_start_r  = r;
                            wp_tmo_left = reg_timeout;
                            wp_ticks    = '0;
                            wp_phase    = WAIT_TURN;
                        end
                    end else begin
                        wp_ticks++;
                        if (wp_ticks >= reg_debounce) begin
                            wp_ticks = '0;
                            if (reg_timeout != 0 && wp_tmo_left <= reg_debounce) begin
                                done = 1'b1;
                            end else begin
                                if (reg_timeout != 0)
                                    wp_tmo_left = wp_tmo_left - reg_debounce;
                                if (wp_press_en && !b)
                                    wp_phase = DEB_DETENT;
                            end
                        end
                    end
                end
                WAIT_TURN: begin
                    if (reg_timeout != 0 && wp_tmo_left == 0) begin
                        done = 1'b1;
                    end else begin
                        turn = EV_NONE;
                        if (wp_start_r) begin
                            if (!r)      turn = EV_RIGHT;
                            else if (!l) turn = EV_LEFT;
                        end else begin
                            if (r)      turn = EV_RIGHT;
                            else if (l) turn = EV_LEFT;
                        end
                        if (turn != EV_NONE) begin
                            wp_held  = turn;
                            wp_ticks = '0;
                            wp_phase = SETTLE_DLY;
                        end else if (wp_press_en && !b) begin
                            wp_ticks = '0;
                            wp_phase = DEB_TURN;
                        end else if (b && wp_press_turn) begin
                            wp_press_turn = 1'b0;
                            ev            = EV_PRESS_END;
                            done          = 1'b1;
                        end else if (wp_tmo_left != 0) begin
                            wp_tmo_left--;
                        end
                    end
                end
                DEB_DETENT, DEB_TURN: begin
                    if (b) begin
                        // released while debouncing: back to the wait it came from
                        wp_ticks = '0;
                        wp_phase = (wp_phase == DEB_DETENT) ? WAIT_DETENT : WAIT_TURN;
                    end else begin
                        wp_ticks++;
                        if (wp_ticks >= reg_debounce) begin
                            wp_start_r = r;
                            wp_start_l = l;
                            wp_ticks   = '0;
                            wp_phase   = BTN_HOLD;
                        end
                    end
                end
                BTN_HOLD: begin
                    if (b) begin
                        ev   = EV_PRESS;
                        done = 1'b1;
                    end else if (wp_ticks >= reg_long) begin
                        ev   = EV_LONG;
                        done = 1'b1;
                    end else if (r != wp_start_r || l != wp_start_l) begin
                        wp_press_turn = 1'b1;
                        ev            = EV_PRESS_BEGIN;
                        done          = 1'b1;
                    end else begin
                        wp_ticks++;
                    end
                end
                SETTLE_DLY: begin
                    wp_ticks++;
                    if (wp_ticks >= reg_debounce) begin
                        wp_ticks = '0;
                        wp_phase = SETTLE_WIN;
                    end
                end
                default: begin
                    if (r == l) begin
                        done = 1'b1;
                        if (r == wp_start_r)
                            ev = EV_NONE;
                        else if (!wp_press_en)
                            ev = (wp_held == EV_LEFT) ? EV_PRESS_LEFT : EV_PRESS_RIGHT;
                        else
                            ev = wp_held;
                    end else begin
                        wp_ticks++;
                        if (wp_ticks >= reg_settle)
                            done = 1'b1;
                    end
                end
            endcase
        end
        if (done) begin
            wp_phase = WAIT_START;
            wp_ticks = '0;
        end
        return done;
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // event checker
    always @(posedge aclk) begin
        wheel_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_events.size() == 0) begin
                $error("wheel_event: unexpected item, got %0d", m_tdata[3:0]);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                if (m_tdata[3:0] !== want) begin
                    $error("wheel_event: expected %0d, got %0d", want, m_tdata[3:0]);
                    error_count++;
                end
            end
        end
    end

    // stall watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_tick(input bit r, input bit l, input bit b);
        wheel_event_t ev;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, b, l, r};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (decode_tick(r, l, b, ev))
            pending_events.push_back(ev);
        ticks_sent++;
    endtask

    // sender holds off until every expected event is out and the pipe is empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_TIMEOUT:  reg_timeout  = value[TIMEOUT_W-1:0];
            CFG_DEBOUNCE: reg_debounce = value[DEBOUNCE_W-1:0];
            CFG_LONG:     reg_long     = value[LONG_W-1:0];
            default:      reg_settle   = value[SETTLE_W-1:0];
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_regs(input int unsigned tmo, input int unsigned deb,
                             input int unsigned hold, input int unsigned settle);
        wait_idle();
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(tmo));
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
        write_reg(CFG_LONG, CFG_DATA_W'(hold));
        write_reg(CFG_SETTLE, CFG_DATA_W'(settle));
    endtask

    // well-formed turns and presses with random timing, plus some noise
    task automatic run_mixed_ticks(input int unsigned n_items);
        int unsigned stop_at, kind, dwell_max, hold_max, hold_len, move_at, i;
        bit          lvl, btn, go_right, mr, ml, lead_r, lead_l, moved, back_home;
        stop_at = ticks_sent + n_items;
        while (ticks_sent < stop_at) begin
            kind = $urandom_range(9);
            lvl  = 1'($urandom_range(1));
            if (kind < 5) begin
                btn      = ($urandom_range(3) != 0);
                go_right = 1'($urandom_range(1));
                repeat ($urandom_range(2, 1)) send_tick(lvl, lvl, btn);
                // a right turn moves the right pin off the detent first
                mr = go_right ? !lvl : lvl;
                ml = go_right ? lvl : !lvl;
                dwell_max = reg_debounce + reg_settle + 2;
                if (dwell_max > 48) dwell_max = 48;
                repeat ($urandom_range(dwell_max, 1)) send_tick(mr, ml, btn);
                back_home = ($urandom_range(3) == 0);
                repeat ($urandom_range(2, 1))
                    send_tick(back_home ? lvl : !lvl, back_home ? lvl : !lvl, btn);
            end else if (kind < 8) begin
                // a lead-in off the detent sends the press through the detent wait, one on it through the turn wait
                lead_r = lvl;
                lead_l = ($urandom_range(2) == 0) ? !lvl : lvl;
                repeat ($urandom_range(2, 1)) send_tick(lead_r, lead_l, 1'b1);
                hold_max = reg_debounce + reg_long + 3;
                if (hold_max > 60) hold_max = 60;
                hold_len = $urandom_range(hold_max);
                moved    = ($urandom_range(2) == 0);
                move_at  = $urandom_range(hold_len);
                for (i = 0; i < hold_len; i++) begin
                    if (moved && i >= move_at)
                        send_tick(!lead_r, lead_l, 1'b0);
                    else
                        send_tick(lead_r, lead_l, 1'b0);
                end
                repeat ($urandom_range(3, 2)) send_tick(lvl, lvl, 1'b1);
            end else begin
                repeat ($urandom_range(6, 1))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
            end
        end
    endtask

    // every event kind and every pin combination, short timings
    task automatic test_directed_events();
        // {pin_button, pin_left, pin_right} per tick
        bit [2:0] seq [34];
        int       i;
        seq = '{3'b100, 3'b101, 3'b101, 3'b111, 3'b111, 3'b101, 3'b101, 3'b100,
                3'b100, 3'b000, 3'b000, 3'b100, 3'b100, 3'b000, 3'b000, 3'b000,
                3'b000, 3'b000, 3'b010, 3'b010, 3'b011, 3'b111, 3'b011, 3'b011,
                3'b010, 3'b110, 3'b011, 3'b010, 3'b010, 3'b000, 3'b111, 3'b001,
                3'b001, 3'b011};
        load_regs(0, 1, 1, 3);
        for (i = 0; i < 34; i++)
            send_tick(seq[i][0], seq[i][1], seq[i][2]);
    endtask

    task automatic test_turns_and_presses();
        load_regs(0, 2, 24, 8);
        run_mixed_ticks(250);
    endtask

    task automatic test_wait_timeouts();
        load_regs(30, 3, 12, 5);
        run_mixed_ticks(150);
    endtask

    task automatic test_register_extremes();
        load_regs(65535, 15, 4095, 1023);
        run_mixed_ticks(80);
    endtask

    // zero counters expire at once; smallest nonzero wait limit
    task automatic test_zero_registers();
        load_regs(1, 0, 0, 0);
        run_mixed_ticks(60);
    endtask

    task automatic test_back_to_back();
        load_regs(0, 3, 40, 20);
        run_mixed_ticks(250);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 17;
        recv_idle_pct = 45;
        test_directed_events();
        test_turns_and_presses();

        send_idle_pct = 45;
        recv_idle_pct = 17;
        test_wait_timeouts();
        test_register_extremes();
        test_zero_registers();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_back_to_back();

        wait_idle();
        if (pending_events.size() != 0) begin
            $error("wheel_event: %0d expected items never arrived", pending_events.size());
            error_count++;
        end
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
